// File: hdl/ltq_pkg.sv
// Shared types and constants of the logical timer queue.
// No dependencies; the cell and the top level import it.
package ltq_pkg;

    localparam int TIMEOUT_W = 64;
    localparam int TAG_W     = 32;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_PERIOD = 2'd1;

    // Result kinds
    localparam logic [1:0] KIND_EXPIRED   = 2'd0;
    localparam logic [1:0] KIND_TICK_DONE = 2'd1;
    localparam logic [1:0] KIND_ADD_STAT  = 2'd2;

    // Chain commands broadcast to every cell
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [TIMEOUT_W-1:0] timeout;
        logic [TAG_W-1:0]     tag;
    } entry_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [TIMEOUT_W-1:0] new_timeout;
        logic [TAG_W-1:0]     new_tag;
    } chain_cmd_t;

endpackage

// File: hdl/ltq_cell.sv
// One slot of the sorted timer chain.
// Depends on ltq_pkg for the entry and command types.
module ltq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ltq_pkg::chain_cmd_t cmd,
    input  ltq_pkg::entry_t    left_entry,
    input  logic               left_keep,
    input  ltq_pkg::entry_t    right_entry,
    output ltq_pkg::entry_t    entry,
    output logic               keep
);
    import ltq_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIMEOUT_W-1:0] timeout_next;
    logic [TAG_W-1:0]     tag_reg;
    logic [TAG_W-1:0]     tag_next;

    // Stay in place on insert when at or below the new timeout (ties go after)
    assign keep = valid_reg && (timeout_reg <= cmd.new_timeout);

    assign entry.valid   = valid_reg;
    assign entry.timeout = timeout_reg;
    assign entry.tag     = tag_reg;

    always_comb
    begin
        valid_next   = valid_reg;
        timeout_next = timeout_reg;
        tag_next     = tag_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next   = 1'b1;
                        timeout_next = cmd.new_timeout;
                        tag_next     = cmd.new_tag;
                    end
                    else
                    begin
                        valid_next   = left_entry.valid;
                        timeout_next = left_entry.timeout;
                        tag_next     = left_entry.tag;
                    end
                end
            end
            OP_POP:
            begin
                valid_next   = right_entry.valid;
                timeout_next = right_entry.timeout;
                tag_next     = right_entry.tag;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        timeout_reg <= timeout_next;
        tag_reg     <= tag_next;
    end

endmodule

// File: hdl/logical_timer_queue_top.sv
// Logical timer queue: a chain of CAPACITY cells kept sorted by timeout.
// Add: insert on acceptance, result registered from ST_ADD once the output is free.
// Tick: ST_POP pops every due entry (k expired, r task timers), then ST_REARM
// re-inserts the r task timers and reports; one item at a time (in_stall outside idle).
// Pace is set by the chain: one entry per cycle on pop or insert, expired pops waiting on out_stall.
// Reset (rst_n, async, active low) empties the chain, clears the tick counter,
// and sets task_marker to 0 and task_period to 1.
module logical_timer_queue_top #(
    parameter int CAPACITY = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [ltq_pkg::TIMEOUT_W-1:0] timeout,
    input  logic signed [ltq_pkg::TAG_W-1:0] value,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic [ltq_pkg::TIMEOUT_W-1:0] expired_at,
    output logic signed [ltq_pkg::TAG_W-1:0] tag,
    output logic                          task_switch,
    output logic                          store_full,
    output logic                          last,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ltq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ltq_pkg::CFG_DAT_W-1:0] cfg_data
);
    import ltq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ADD   = 2'd1;
    localparam logic [1:0] ST_POP   = 2'd2;
    localparam logic [1:0] ST_REARM = 2'd3;

    // Control state
    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [TIMEOUT_W-1:0] tick_reg;
    logic [TIMEOUT_W-1:0] tick_next;
    logic [CNT_W-1:0]     rearm_cnt_reg;
    logic [CNT_W-1:0]     rearm_cnt_next;
    logic                 switch_reg;
    logic                 switch_next;
    logic                 full_reg;
    logic                 full_next;
    logic [TIMEOUT_W-1:0] arm_reg;
    logic [TIMEOUT_W-1:0] arm_next;

    // Configuration registers
    logic [TAG_W-1:0]     marker_reg;
    logic [PERIOD_W-1:0]  period_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           kind_reg;
    logic [1:0]           kind_next;
    logic [TIMEOUT_W-1:0] at_reg;
    logic [TIMEOUT_W-1:0] at_next;
    logic [TAG_W-1:0]     tag_reg;
    logic [TAG_W-1:0]     tag_next;
    logic                 sw_reg;
    logic                 sw_next;
    logic                 full_out_reg;
    logic                 full_out_next;
    logic                 last_reg;
    logic                 last_next;

    // Chain
    chain_cmd_t           cmd;
    entry_t               cells [CAPACITY];
    logic                 keeps [CAPACITY];

    logic                 in_take;
    logic                 out_free;
    logic                 head_due;
    logic [PERIOD_W-1:0]  period_eff;
    logic [TIMEOUT_W:0]   arm_sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Head of the chain is always the earliest timer
    assign head_due = cells[0].valid && (cells[0].timeout <= tick_reg);

    // Re-arm point: tick plus period, period zero read as one, saturating
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign arm_sum    = {1'b0, tick_reg} + {{(TIMEOUT_W - PERIOD_W + 1){1'b0}}, period_eff};

    // Cell row: each slot sees its neighbors and the broadcast command
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;
            if (gi == 0)
            begin : g_first
                assign left_e = '0;
                assign left_k = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = cells[gi-1];
                assign left_k = keeps[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cells[gi+1];
            end
            ltq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .entry       (cells[gi]),
                .keep        (keeps[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        rearm_cnt_next = rearm_cnt_reg;
        switch_next    = switch_reg;
        full_next      = full_reg;
        arm_next       = arm_reg;
        cmd.op          = OP_HOLD;
        cmd.new_timeout = timeout;
        cmd.new_tag     = value;

        // Drop the held result once taken
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        at_next        = at_reg;
        tag_next       = tag_reg;
        sw_next        = sw_reg;
        full_out_next  = full_out_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (func)
                    begin
                        // Insert at once unless the last slot is taken
                        full_next = cells[CAPACITY-1].valid;
                        if (!cells[CAPACITY-1].valid)
                        begin
                            cmd.op = OP_INSERT;
                        end
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        tick_next      = tick_reg + TIMEOUT_W'(1);
                        rearm_cnt_next = '0;
                        switch_next    = 1'b0;
                        state_next     = ST_POP;
                    end
                end
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ADD_STAT;
                    at_next        = '0;
                    tag_next       = '0;
                    sw_next        = 1'b0;
                    full_out_next  = full_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (head_due)
                begin
                    if (cells[0].tag == marker_reg)
                    begin
                        // Task timer: count it for re-arm, report nothing
                        cmd.op         = OP_POP;
                        switch_next    = 1'b1;
                        rearm_cnt_next = rearm_cnt_reg + CNT_W'(1);
                    end
                    else if (out_free)
                    begin
                        cmd.op         = OP_POP;
                        out_valid_next = 1'b1;
                        kind_next      = KIND_EXPIRED;
                        at_next        = cells[0].timeout;
                        tag_next       = cells[0].tag;
                        sw_next        = 1'b0;
                        full_out_next  = 1'b0;
                        last_next      = 1'b0;
                    end
                end
                else
                begin
                    arm_next   = arm_sum[TIMEOUT_W] ? '1 : arm_sum[TIMEOUT_W-1:0];
                    state_next = ST_REARM;
                end
            end
            ST_REARM:
            begin
                cmd.new_timeout = arm_reg;
                cmd.new_tag     = marker_reg;
                if (rearm_cnt_reg != '0)
                begin
                    // Slots freed by the pops guarantee room
                    cmd.op         = OP_INSERT;
                    rearm_cnt_next = rearm_cnt_reg - CNT_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TICK_DONE;
                    at_next        = '0;
                    tag_next       = '0;
                    sw_next        = switch_reg;
                    full_out_next  = 1'b0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            rearm_cnt_reg <= '0;
            switch_reg    <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            marker_reg    <= '0;
            period_reg    <= PERIOD_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            rearm_cnt_reg <= rearm_cnt_next;
            switch_reg    <= switch_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TASK_MARKER: marker_reg <= cfg_data[TAG_W-1:0];
                    CFG_TASK_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    default:         marker_reg <= marker_reg;
                endcase
            end
        end
    end

    // Result payload and re-arm point need no reset
    always_ff @(posedge clk)
    begin
        arm_reg      <= arm_next;
        kind_reg     <= kind_next;
        at_reg       <= at_next;
        tag_reg      <= tag_next;
        sw_reg       <= sw_next;
        full_out_reg <= full_out_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign expired_at  = at_reg;
    assign tag         = tag_reg;
    assign task_switch = sw_reg;
    assign store_full  = full_out_reg;
    assign last        = last_reg;

endmodule
